/* src/doubly_linked_list_engine_assert.svh */
// assertion macros for the doubly linked list engine
// included by the top level; no other dependencies
`ifndef DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
`define DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define DLLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlle assertion failed");

// next-cycle implication, checked out of reset
`define DLLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlle assertion failed");

`else

`define DLLE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DLLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/dlle_pkg.sv */
// shared types and constants for the doubly linked list engine
// no dependencies
package dlle_pkg;

  localparam int POOL_NODES = 16;
  localparam int VALUE_BITS = 32;
  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int LINK_W     = $clog2(POOL_NODES + 1);
  localparam int CNT_W      = $clog2(POOL_NODES + 1);
  localparam logic [LINK_W-1:0] SENT = LINK_W'(POOL_NODES);

  typedef enum logic [2:0] {
    FUNC_PUSH_BACK  = 3'd0,
    FUNC_PUSH_FRONT = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_FIND       = 3'd4,
    FUNC_ERASE      = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_BAD_HANDLE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UNLINK,
    S_LINK,
    S_SPLICE,
    S_FIND_RD,
    S_FIND_CMP,
    S_DONE
  } state_e;

  // write port of a link memory
  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

  // write port of the value memory
  typedef struct packed {
    logic                  en;
    logic [NODE_W-1:0]     addr;
    logic [VALUE_BITS-1:0] data;
  } val_wr_t;

endpackage

/* src/doubly_linked_list_engine.sv */
// top level of the doubly linked list engine: sequencer, sentinel links,
// in-use bits and result register; uses dlle_pkg and dlle_node_store
//
//   channel | signals                                   | direction
//   request | in_valid_i, in_stall_o, func_i,           | in
//           | data_value_i, node_handle_i               |
//   result  | out_valid_o, out_stall_i, status_o,       | out
//           | out_handle_o, out_data_o, list_length_o   |
//
// push steps: accept, node links, neighbor links, result
// pop and erase steps: accept, link read, unlink, result
// full push, empty pop, bad handle, empty find and unused codes: accept, then result
// find: accept, then a read and one compare per node visited, then result
// reset clears the in-use bits, count and sentinel links at once; no sweep
// a new request is taken only when idle; a stalled result holds the engine
module doubly_linked_list_engine import dlle_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            func_i,
  input  logic [VALUE_BITS-1:0] data_value_i,
  input  logic [NODE_W-1:0]     node_handle_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            status_o,
  output logic [NODE_W-1:0]     out_handle_o,
  output logic [VALUE_BITS-1:0] out_data_o,
  output logic [CNT_W-1:0]      list_length_o
);

`include "doubly_linked_list_engine_assert.svh"

  // control state
  state_e                  state_q, state_d;
  logic [LINK_W-1:0]       sent_next_q, sent_next_d;
  logic [LINK_W-1:0]       sent_prev_q, sent_prev_d;
  logic [POOL_NODES-1:0]   in_use_q, in_use_d;
  logic [CNT_W-1:0]        total_q, total_d;
  logic                    out_valid_q, out_valid_d;

  // working and payload registers
  logic [NODE_W-1:0]       node_q, node_d;
  logic [LINK_W-1:0]       prv_q, prv_d;
  logic [LINK_W-1:0]       nxt_q, nxt_d;
  logic [VALUE_BITS-1:0]   val_q, val_d;
  status_e                 res_status_q, res_status_d;
  logic [NODE_W-1:0]       res_handle_q, res_handle_d;
  logic [VALUE_BITS-1:0]   res_data_q, res_data_d;
  status_e                 out_status_q, out_status_d;
  logic [NODE_W-1:0]       out_handle_q, out_handle_d;
  logic [VALUE_BITS-1:0]   out_data_q, out_data_d;
  logic [CNT_W-1:0]        out_len_q, out_len_d;

  // memory ports
  link_wr_t                next_wr, prev_wr;
  val_wr_t                 val_wr;
  logic [LINK_W-1:0]       next_rd, prev_rd;
  logic [VALUE_BITS-1:0]   val_rd;

  // lowest free node
  logic                    free_found;
  logic [NODE_W-1:0]       free_idx;

  logic                    out_free;

  dlle_node_store u_store (
    .clk_i     (clk_i),
    .next_wr_i (next_wr),
    .prev_wr_i (prev_wr),
    .val_wr_i  (val_wr),
    .rd_addr_i (node_q),
    .next_rd_o (next_rd),
    .prev_rd_o (prev_rd),
    .val_rd_o  (val_rd)
  );

  // priority search for the lowest free node
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = POOL_NODES - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = NODE_W'(i);
      end
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // sequencer: next state, link updates and result
  always_comb begin
    state_d      = state_q;
    sent_next_d  = sent_next_q;
    sent_prev_d  = sent_prev_q;
    in_use_d     = in_use_q;
    total_d      = total_q;
    node_d       = node_q;
    prv_d        = prv_q;
    nxt_d        = nxt_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_data_d   = res_data_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_handle_d = out_handle_q;
    out_data_d   = out_data_q;
    out_len_d    = out_len_q;
    next_wr      = '0;
    prev_wr      = '0;
    val_wr       = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_handle_d = '0;
          res_data_d   = '0;
          val_d        = data_value_i;
          state_d      = S_DONE;
          case (func_i)
            FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
              if (free_found) begin
                node_d       = free_idx;
                prv_d        = (func_i == FUNC_PUSH_BACK) ? sent_prev_q : SENT;
                nxt_d        = (func_i == FUNC_PUSH_BACK) ? SENT : sent_next_q;
                res_handle_d = free_idx;
                res_data_d   = data_value_i;
                state_d      = S_LINK;
              end else begin
                res_status_d = ST_FULL;
              end
            end
            FUNC_POP_FRONT: begin
              if (sent_next_q == SENT) begin
                res_status_d = ST_EMPTY;
              end else begin
                node_d  = sent_next_q[NODE_W-1:0];
                state_d = S_READ;
              end
            end
            FUNC_POP_BACK: begin
              if (sent_prev_q == SENT) begin
                res_status_d = ST_EMPTY;
              end else begin
                node_d  = sent_prev_q[NODE_W-1:0];
                state_d = S_READ;
              end
            end
            FUNC_FIND: begin
              if (sent_next_q == SENT) begin
                res_status_d = ST_NOT_FOUND;
              end else begin
                node_d  = sent_next_q[NODE_W-1:0];
                state_d = S_FIND_RD;
              end
            end
            FUNC_ERASE: begin
              if (in_use_q[node_handle_i]) begin
                node_d  = node_handle_i;
                state_d = S_READ;
              end else begin
                res_status_d = ST_BAD_HANDLE;
              end
            end
            default: begin
              // unused codes give an ok result and change nothing
              res_status_d = ST_OK;
            end
          endcase
        end
      end

      // links and value of the node arrive from the memories
      S_READ: begin
        state_d = S_UNLINK;
      end

      // bridge the neighbors over the node and free it
      S_UNLINK: begin
        if (prev_rd == SENT) begin
          sent_next_d = next_rd;
        end else begin
          next_wr = '{en: 1'b1, addr: prev_rd[NODE_W-1:0], data: next_rd};
        end
        if (next_rd == SENT) begin
          sent_prev_d = prev_rd;
        end else begin
          prev_wr = '{en: 1'b1, addr: next_rd[NODE_W-1:0], data: prev_rd};
        end
        in_use_d[node_q] = 1'b0;
        total_d          = total_q - CNT_W'(1);
        res_status_d     = ST_OK;
        res_handle_d     = node_q;
        res_data_d       = val_rd;
        state_d          = S_DONE;
      end

      // new node's own links and value
      S_LINK: begin
        next_wr          = '{en: 1'b1, addr: node_q, data: nxt_q};
        prev_wr          = '{en: 1'b1, addr: node_q, data: prv_q};
        val_wr           = '{en: 1'b1, addr: node_q, data: val_q};
        in_use_d[node_q] = 1'b1;
        total_d          = total_q + CNT_W'(1);
        state_d          = S_SPLICE;
      end

      // neighbors point at the new node
      S_SPLICE: begin
        if (prv_q == SENT) begin
          sent_next_d = LINK_W'(node_q);
        end else begin
          next_wr = '{en: 1'b1, addr: prv_q[NODE_W-1:0], data: LINK_W'(node_q)};
        end
        if (nxt_q == SENT) begin
          sent_prev_d = LINK_W'(node_q);
        end else begin
          prev_wr = '{en: 1'b1, addr: nxt_q[NODE_W-1:0], data: LINK_W'(node_q)};
        end
        state_d = S_DONE;
      end

      // wait for the visited node's value and next link
      S_FIND_RD: begin
        state_d = S_FIND_CMP;
      end

      // one compare per visited node
      S_FIND_CMP: begin
        if (val_rd == val_q) begin
          res_status_d = ST_OK;
          res_handle_d = node_q;
          res_data_d   = val_q;
          state_d      = S_DONE;
        end else if (next_rd == SENT) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_DONE;
        end else begin
          node_d  = next_rd[NODE_W-1:0];
          state_d = S_FIND_RD;
        end
      end

      // hand the result over once the output register is free
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_handle_d = res_handle_q;
          out_data_d   = res_data_q;
          out_len_d    = total_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sent_next_q <= SENT;
      sent_prev_q <= SENT;
      in_use_q    <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sent_next_q <= sent_next_d;
      sent_prev_q <= sent_prev_d;
      in_use_q    <= in_use_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    node_q       <= node_d;
    prv_q        <= prv_d;
    nxt_q        <= nxt_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    res_data_q   <= res_data_d;
    out_status_q <= out_status_d;
    out_handle_q <= out_handle_d;
    out_data_q   <= out_data_d;
    out_len_q    <= out_len_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_handle_o  = out_handle_q;
  assign out_data_o    = out_data_q;
  assign list_length_o = out_len_q;

  // node count tracks the in-use bits
  `DLLE_ASSERT_NOW(a_count_match, clk_i, rst_ni, 1'b1, $countones(in_use_q) == total_q)
  // an empty list has a self-linked sentinel
  `DLLE_ASSERT_NOW(a_empty_sentinel, clk_i, rst_ni, total_q == '0,
                   sent_next_q == SENT && sent_prev_q == SENT)
  // a finished request reaches the output once it is free
  `DLLE_ASSERT_NEXT(a_done_delivers, clk_i, rst_ni, state_q == S_DONE && out_free,
                    out_valid_q && state_q == S_IDLE)

endmodule

/* src/dlle_node_store.sv */
// node pool storage: next links, prev links and values, one write and
// one registered read each per cycle; uses dlle_pkg
module dlle_node_store import dlle_pkg::*; (
  input  logic                  clk_i,
  input  link_wr_t              next_wr_i,
  input  link_wr_t              prev_wr_i,
  input  val_wr_t               val_wr_i,
  input  logic [NODE_W-1:0]     rd_addr_i,
  output logic [LINK_W-1:0]     next_rd_o,
  output logic [LINK_W-1:0]     prev_rd_o,
  output logic [VALUE_BITS-1:0] val_rd_o
);

  logic [LINK_W-1:0]     next_mem [POOL_NODES];
  logic [LINK_W-1:0]     prev_mem [POOL_NODES];
  logic [VALUE_BITS-1:0] val_mem  [POOL_NODES];

  // next link memory
  always_ff @(posedge clk_i) begin
    if (next_wr_i.en) begin
      next_mem[next_wr_i.addr] <= next_wr_i.data;
    end
    next_rd_o <= next_mem[rd_addr_i];
  end

  // prev link memory
  always_ff @(posedge clk_i) begin
    if (prev_wr_i.en) begin
      prev_mem[prev_wr_i.addr] <= prev_wr_i.data;
    end
    prev_rd_o <= prev_mem[rd_addr_i];
  end

  // value memory
  always_ff @(posedge clk_i) begin
    if (val_wr_i.en) begin
      val_mem[val_wr_i.addr] <= val_wr_i.data;
    end
    val_rd_o <= val_mem[rd_addr_i];
  end

endmodule

/* sim/doubly_linked_list_engine_tb.sv */
// self-checking testbench for the doubly linked list engine: directed and random
// list operations with random idle and stall, checked against a shadow list
// depends on dlle_pkg and doubly_linked_list_engine
`timescale 1ns / 100ps

module doubly_linked_list_engine_tb;
  import dlle_pkg::*;

  localparam int          CLK_PERIOD    = 10;
  localparam int          RESET_CYCLES  = 9;
  localparam int          RANDOM_ITEMS  = 500;
  localparam int          MAX_IDLE      = 13;
  localparam int          DRAIN_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int          REPORT_LIMIT  = 10;
  localparam int          SENTINEL      = POOL_NODES;
  // codes the engine must ignore
  localparam logic [2:0]  FUNC_SPARE_6  = 3'd6;
  localparam logic [2:0]  FUNC_SPARE_7  = 3'd7;

  typedef struct {
    logic [2:0]            func;
    logic [VALUE_BITS-1:0] value;
    logic [NODE_W-1:0]     handle;
  } list_req_t;

  typedef struct {
    logic [2:0]            func;
    status_e               status;
    logic [NODE_W-1:0]     handle;
    logic [VALUE_BITS-1:0] data;
    logic [CNT_W-1:0]      length;
  } list_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [2:0]            func_i        = '0;
  logic [VALUE_BITS-1:0] data_value_i  = '0;
  logic [NODE_W-1:0]     node_handle_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [2:0]            status_o;
  logic [NODE_W-1:0]     out_handle_o;
  logic [VALUE_BITS-1:0] out_data_o;
  logic [CNT_W-1:0]      list_length_o;

  // shadow copy of the list
  logic [VALUE_BITS-1:0] node_val  [POOL_NODES];
  int unsigned           link_next [POOL_NODES+1];
  int unsigned           link_prev [POOL_NODES+1];
  bit                    node_used [POOL_NODES];
  int unsigned           used_count;

  list_req_t    request_q [$];
  list_result_t expected_q [$];
  list_req_t    cur_req;
  int unsigned  total_reqs;
  int unsigned  sent_cnt;
  int unsigned  mismatch_cnt;
  int unsigned  cycle_cnt;
  int unsigned  drv_gap;
  int unsigned  mon_wait;
  bit           drv_quiet;
  bit           mon_quiet;

  doubly_linked_list_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .data_value_i  (data_value_i),
    .node_handle_i (node_handle_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_handle_o  (out_handle_o),
    .out_data_o    (out_data_o),
    .list_length_o (list_length_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // take a node out of the shadow list and free it
  function automatic void unlink_node(int unsigned node);
    int unsigned p;
    int unsigned q;
    p = link_prev[node];
    q = link_next[node];
    link_next[p]    = q;
    link_prev[q]    = p;
    node_used[node] = 1'b0;
    if (used_count > 0) used_count--;
  endfunction

  // apply one operation to the shadow list and return the result it gives
  function automatic list_result_t apply_list_op(list_req_t req);
    list_result_t res;
    int unsigned  slot;
    int unsigned  cur;
    int unsigned  prv;
    int unsigned  nxt;
    int unsigned  steps;
    res.func   = req.func;
    res.status = ST_OK;
    res.handle = '0;
    res.data   = '0;
    case (req.func)
      FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
        // lowest free node wins
        slot = SENTINEL;
        for (int i = POOL_NODES - 1; i >= 0; i--) begin
          if (!node_used[i]) slot = i;
        end
        if (slot == SENTINEL) begin
          res.status = ST_FULL;
        end else begin
          if (req.func == FUNC_PUSH_BACK) begin
            prv = link_prev[SENTINEL];
            nxt = SENTINEL;
          end else begin
            prv = SENTINEL;
            nxt = link_next[SENTINEL];
          end
          node_val[slot]  = req.value;
          link_next[slot] = nxt;
          link_prev[slot] = prv;
          link_next[prv]  = slot;
          link_prev[nxt]  = slot;
          node_used[slot] = 1'b1;
          used_count++;
          res.handle = NODE_W'(slot);
          res.data   = req.value;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        cur = (req.func == FUNC_POP_FRONT) ? link_next[SENTINEL] : link_prev[SENTINEL];
        if (cur == SENTINEL || used_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.handle = NODE_W'(cur);
          res.data   = node_val[cur];
          unlink_node(cur);
        end
      end
      FUNC_FIND: begin
        // walk from the front, first match wins
        res.status = ST_NOT_FOUND;
        cur        = link_next[SENTINEL];
        steps      = 0;
        while (cur != SENTINEL && steps < POOL_NODES && res.status != ST_OK) begin
          if (node_val[cur] == req.value) begin
            res.status = ST_OK;
            res.handle = NODE_W'(cur);
            res.data   = req.value;
          end else begin
            cur = link_next[cur];
          end
          steps++;
        end
      end
      FUNC_ERASE: begin
        if (!node_used[req.handle]) begin
          res.status = ST_BAD_HANDLE;
        end else begin
          res.handle = req.handle;
          res.data   = node_val[req.handle];
          unlink_node(req.handle);
        end
      end
      default: ;
    endcase
    res.length = CNT_W'(used_count);
    return res;
  endfunction

  function automatic list_req_t mk_req(logic [2:0] f, logic [VALUE_BITS-1:0] v,
                                       logic [NODE_W-1:0] h);
    list_req_t req;
    req.func   = f;
    req.value  = v;
    req.handle = h;
    return req;
  endfunction

  // random request, weighted toward growing or shrinking the list
  function automatic list_req_t rand_req(bit filling);
    list_req_t   req;
    int unsigned pick;
    // values mostly from a small set so that finds hit
    case ($urandom_range(0, 9))
      0:       req.value = '0;
      1:       req.value = VALUE_BITS'(1);
      2:       req.value = '1;
      3:       req.value = 32'h5a5a_a5a5;
      4:       req.value = 32'h8000_0000;
      5:       req.value = 32'h7fff_ffff;
      default: req.value = $urandom;
    endcase
    req.handle = NODE_W'($urandom_range(0, POOL_NODES - 1));
    pick       = $urandom_range(0, 99);
    if (pick < 2)
      req.func = (pick == 0) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    else if (pick < (filling ? 72 : 22))
      req.func = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
    else if (pick < (filling ? 86 : 38))
      req.func = FUNC_FIND;
    else if (pick < (filling ? 94 : 68))
      req.func = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
    else
      req.func = FUNC_ERASE;
    return req;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(apply_list_op(cur_req));
        sent_cnt++;
        if ($urandom_range(0, 29) == 0) drv_quiet = !drv_quiet;
        drv_gap = drv_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      end
      // a stalled request holds its payload
      if (!(in_valid_i && in_stall_o)) begin
        if (drv_gap != 0) begin
          drv_gap--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          cur_req = request_q.pop_front();
          in_valid_i    <= 1'b1;
          func_i        <= cur_req.func;
          data_value_i  <= cur_req.value;
          node_handle_i <= cur_req.handle;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin : result_monitor
    list_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT)
            $display("%0t: result with no request pending: status %0d handle %0d",
                     $realtime, status_o, out_handle_o,
                     " data %h len %0d", out_data_o, list_length_o);
        end else begin
          want = expected_q.pop_front();
          if (status_o !== want.status || out_handle_o !== want.handle ||
              out_data_o !== want.data || list_length_o !== want.length) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT) begin
              $display("%0t: result mismatch for func %0d", $realtime, want.func);
              $display("  expected status %0d handle %0d data %h len %0d",
                       want.status, want.handle, want.data, want.length);
              $display("  actual   status %0d handle %0d data %h len %0d",
                       status_o, out_handle_o, out_data_o, list_length_o);
            end
          end
        end
        if ($urandom_range(0, 29) == 0) mon_quiet = !mon_quiet;
        mon_wait = mon_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      end else if (out_valid_o && mon_wait != 0) begin
        mon_wait--;
      end
      out_stall_i <= (mon_wait != 0);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // empty shadow list: sentinel points to itself
    for (int i = 0; i < POOL_NODES; i++) begin
      node_val[i]  = '0;
      node_used[i] = 1'b0;
    end
    for (int i = 0; i <= POOL_NODES; i++) begin
      link_next[i] = SENTINEL;
      link_prev[i] = SENTINEL;
    end
    used_count   = 0;
    sent_cnt     = 0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    drv_gap      = 0;
    mon_wait     = 0;
    drv_quiet    = 1'b0;
    mon_quiet    = 1'b0;

    // directed: operations on an empty list, ignored codes
    request_q.push_back(mk_req(FUNC_POP_FRONT, '0, '0));
    request_q.push_back(mk_req(FUNC_POP_BACK, '0, '0));
    request_q.push_back(mk_req(FUNC_FIND, '0, '0));
    request_q.push_back(mk_req(FUNC_ERASE, '0, '0));
    request_q.push_back(mk_req(FUNC_SPARE_6, '1, '1));
    request_q.push_back(mk_req(FUNC_SPARE_7, 32'h8000_0000, '0));
    // directed: value extremes at both ends
    request_q.push_back(mk_req(FUNC_PUSH_BACK, 32'h8000_0000, '0));
    request_q.push_back(mk_req(FUNC_PUSH_FRONT, 32'h7fff_ffff, '0));
    request_q.push_back(mk_req(FUNC_PUSH_BACK, '1, '1));
    request_q.push_back(mk_req(FUNC_FIND, '1, '0));
    request_q.push_back(mk_req(FUNC_FIND, 32'h7fff_ffff, '0));
    request_q.push_back(mk_req(FUNC_FIND, 32'h1234_5678, '0));
    // directed: erase at the front, erase of a freed node and of an unused one
    request_q.push_back(mk_req(FUNC_ERASE, '0, NODE_W'(1)));
    request_q.push_back(mk_req(FUNC_ERASE, '0, NODE_W'(1)));
    request_q.push_back(mk_req(FUNC_ERASE, '0, '1));
    request_q.push_back(mk_req(FUNC_POP_FRONT, '0, '0));
    request_q.push_back(mk_req(FUNC_POP_BACK, '0, '0));
    request_q.push_back(mk_req(FUNC_POP_BACK, '0, '0));

    // random: alternating fill and drain stretches reach full and empty
    begin
      int  remaining;
      int  run_len;
      bit  filling;
      remaining = RANDOM_ITEMS;
      filling   = 1'b1;
      while (remaining > 0) begin
        run_len = $urandom_range(8, 40);
        for (int i = 0; i < run_len && remaining > 0; i++) begin
          request_q.push_back(rand_req(filling));
          remaining--;
        end
        filling = !filling;
      end
    end
    total_reqs = request_q.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (sent_cnt == total_reqs);
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatch_cnt += expected_q.size();

    if (mismatch_cnt == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/dlle_pkg.sv
src/dlle_node_store.sv
src/doubly_linked_list_engine.sv
sim/doubly_linked_list_engine_tb.sv
